// ----- rtl/sa_pkg.sv -----
// Shared types and constants for the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package sa_pkg;

    // Default table size.
    localparam int MAX_SLOTS_DEF = 64;

    // Allocation stops below 128 because the limit register is 7 bits wide,
    // and release can only name slots below 64, so no slot at or above 128
    // can ever become active.
    localparam int SCAN_REACH = 128;

    // Slots examined per scan cycle.
    localparam int CHUNK = 16;

    // Configuration register width and reset value.
    localparam int LIMIT_W = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

    // Request codes.
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // Controller states.
    typedef enum logic [0:0] {
        SA_IDLE,
        SA_WORK
    } sa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic advance;
        logic commit;
    } sa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_busy;
    } sa_status_t;

endpackage

`default_nettype wire

// ----- rtl/slot_allocator_with_free_hint.sv -----
// Release, clear and undefined requests are latched on acceptance and give their result from the work state.
// Allocate scans N 16-slot chunks, starting at the hint's chunk (1 to 4 at 64 slots),
// with a scan window of one chunk per cycle.
// A new request is taken the cycle after a result is registered, while that result may wait.
// Reset empties the table, zeroes count and hint, sets the limit register to 64, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module slot_allocator_with_free_hint #(
    parameter int MAX_SLOTS = sa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 kind,
    input  wire logic [5:0]                 slot,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [5:0]                      granted_slot,
    output logic                            ok,
    output logic [6:0]                      active_count,
    input  wire logic                       cfg_we,
    input  wire logic [sa_pkg::LIMIT_W-1:0] cfg_data
);

    sa_pkg::sa_cmd_t    cmd;
    sa_pkg::sa_status_t status;

    // Request sequencing.
    sa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table, scan and result register.
    sa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .slot         (slot),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .granted_slot (granted_slot),
        .ok           (ok),
        .active_count (active_count)
    );

endmodule

`default_nettype wire

// ----- rtl/sa_ctrl.sv -----
// Controller state machine for the slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module sa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sa_pkg::sa_status_t status,
    output sa_pkg::sa_cmd_t         cmd
);

    sa_pkg::sa_state_t state_reg;
    sa_pkg::sa_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sa_pkg::SA_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: one request is worked on at a time.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sa_pkg::SA_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sa_pkg::SA_WORK;
                end
            end
            sa_pkg::SA_WORK:
            begin
                if (status.done && !status.out_busy)
                begin
                    state_next = sa_pkg::SA_IDLE;
                end
            end
            default:
            begin
                state_next = sa_pkg::SA_IDLE;
            end
        endcase
    end

    // Outputs: load on accept, scan until done, commit once the output is free.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            sa_pkg::SA_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sa_pkg::SA_WORK:
            begin
                cmd.advance = !status.done;
                cmd.commit  = status.done && !status.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sa_datapath.sv -----
// Datapath for the slot allocator: active bitmap, count, hint and result register.
`timescale 1ns / 1ps
`default_nettype none

module sa_datapath #(
    parameter int MAX_SLOTS = sa_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sa_pkg::sa_cmd_t            cmd,
    output sa_pkg::sa_status_t              status,
    input  wire logic [1:0]                 kind,
    input  wire logic [5:0]                 slot,
    input  wire logic                       cfg_we,
    input  wire logic [sa_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [5:0]                      granted_slot,
    output logic                            ok,
    output logic [6:0]                      active_count
);

    // Only slots below SCAN_REACH can ever be active, so only those are stored.
    localparam int TBL    = (MAX_SLOTS < sa_pkg::SCAN_REACH) ? MAX_SLOTS
                                                             : sa_pkg::SCAN_REACH;
    localparam int CHUNK  = sa_pkg::CHUNK;
    localparam int NCHUNK = (TBL + CHUNK - 1) / CHUNK;
    localparam int NBITS  = NCHUNK * CHUNK;
    localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int OFF_W  = $clog2(CHUNK);
    localparam int HINT_W = $clog2(TBL + 1);
    localparam int CNT_W  = $clog2(TBL + 1);
    localparam int POS_W  = $clog2(NBITS + 1);

    // State and payload registers.
    logic [NCHUNK-1:0][CHUNK-1:0] map_reg, map_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [HINT_W-1:0]            hint_reg, hint_next;
    logic [sa_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [5:0]                   slot_reg, slot_next;
    logic [CIDX_W-1:0]            cidx_reg, cidx_next;
    logic [5:0]                   granted_reg, granted_next;
    logic                         ok_reg, ok_next;

    // Scan and release evaluation.
    logic [HINT_W-1:0] lim;
    logic [POS_W-1:0]  lim_pos;
    logic [POS_W-1:0]  hint_pos;
    logic [POS_W-1:0]  base;
    logic [CHUNK-1:0]  chunk;
    logic [CHUNK-1:0]  free;
    logic [OFF_W-1:0]  first;
    logic              found;
    logic              alloc_ok;
    logic              alloc_fail;
    logic [POS_W-1:0]  grant_pos;
    logic              slot_in;
    logic              slot_bit;
    logic              rel_ok;

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            count_reg     <= '0;
            hint_reg      <= '0;
            limit_reg     <= sa_pkg::LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            map_reg       <= map_next;
            count_reg     <= count_next;
            hint_reg      <= hint_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        slot_reg    <= slot_next;
        cidx_reg    <= cidx_next;
        granted_reg <= granted_next;
        ok_reg      <= ok_next;
    end

    // Usable limit is the register clamped to the table size.
    always_comb
    begin
        if (int'(limit_reg) > TBL)
        begin
            lim = HINT_W'(TBL);
        end
        else
        begin
            lim = HINT_W'(limit_reg);
        end
        lim_pos  = POS_W'(lim);
        hint_pos = POS_W'(hint_reg);
    end

    // One chunk of the bitmap is searched per cycle for the first free slot.
    always_comb
    begin
        base  = POS_W'(cidx_reg) << OFF_W;
        chunk = map_reg[cidx_reg];
        for (int j = 0; j < CHUNK; j++)
        begin
            free[j] = !chunk[j] && ((base + POS_W'(j)) < lim_pos);
        end
        first = '0;
        for (int j = CHUNK - 1; j >= 0; j--)
        begin
            if (free[j])
            begin
                first = OFF_W'(j);
            end
        end
        found      = |free;
        grant_pos  = base + POS_W'(first);
        alloc_ok   = found && (hint_pos < lim_pos);
        alloc_fail = (hint_pos >= lim_pos)
                     || (!found && ((base + POS_W'(CHUNK)) >= lim_pos));
    end

    // Release looks up the named slot directly.
    always_comb
    begin
        slot_in  = int'(slot_reg) < TBL;
        slot_bit = map_reg[CIDX_W'(slot_reg >> OFF_W)][slot_reg[OFF_W-1:0]];
        rel_ok   = slot_in && slot_bit;
    end

    // Status back to the controller.
    always_comb
    begin
        status.done     = (kind_reg != sa_pkg::KIND_ALLOC) || alloc_ok || alloc_fail;
        status.out_busy = out_valid_reg && !out_ready;
    end

    // Next-state logic for the table, request latch and result register.
    always_comb
    begin
        map_next       = map_reg;
        count_next     = count_reg;
        hint_next      = hint_reg;
        limit_next     = limit_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        cidx_next      = cidx_reg;
        granted_next   = granted_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            limit_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Latch the request and start the scan at the hint's chunk.
        if (cmd.load)
        begin
            kind_next = kind;
            slot_next = slot;
            cidx_next = CIDX_W'(hint_reg >> OFF_W);
        end

        if (cmd.advance)
        begin
            cidx_next = cidx_reg + CIDX_W'(1);
        end

        // Apply the request and present its result.
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            granted_next   = '0;
            ok_next        = 1'b0;
            case (kind_reg)
                sa_pkg::KIND_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        map_next[cidx_reg][first] = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        hint_next    = HINT_W'(grant_pos + POS_W'(1));
                        granted_next = 6'(grant_pos);
                        ok_next      = 1'b1;
                    end
                end
                sa_pkg::KIND_RELEASE:
                begin
                    if (rel_ok)
                    begin
                        map_next[CIDX_W'(slot_reg >> OFF_W)][slot_reg[OFF_W-1:0]] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        if (HINT_W'(slot_reg) < hint_reg)
                        begin
                            hint_next = HINT_W'(slot_reg);
                        end
                        ok_next = 1'b1;
                    end
                end
                sa_pkg::KIND_CLEAR:
                begin
                    map_next   = '0;
                    count_next = '0;
                    hint_next  = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    // The count changes only together with a new result, so it drives the port directly.
    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_reg;
    assign ok           = ok_reg;
    assign active_count = 7'(count_reg);

endmodule

`default_nettype wire
